FILE: hw/rtl/ccdrbg_pkg.sv
// ----------------------------------------------------------------------------
// ccdrbg_pkg
// Shared types and constants of the ChaCha20 keystream generator.
// ----------------------------------------------------------------------------
package ccdrbg_pkg;

  localparam int unsigned DoubleRoundsDefault = 10;
  localparam int unsigned NumCfg = 7;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 64;
  localparam int unsigned QueueDepth = 2;

  localparam logic [1:0] ModeSeed     = 2'd0;
  localparam logic [1:0] ModeEntropy  = 2'd1;
  localparam logic [1:0] ModeGenerate = 2'd2;
  localparam logic [1:0] ModeUnused   = 2'd3;

  localparam logic [CfgIdxW-1:0] CfgSeed0  = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgSeed1  = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgSeed2  = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgSeed3  = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgNonceA = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgNonceB = 3'd5;
  localparam logic [CfgIdxW-1:0] CfgNonceC = 3'd6;

  localparam logic [31:0] Sigma0 = 32'h61707865;
  localparam logic [31:0] Sigma1 = 32'h3320646e;
  localparam logic [31:0] Sigma2 = 32'h79622d32;
  localparam logic [31:0] Sigma3 = 32'h6b206574;

  typedef struct packed {
    logic [1:0]  mode;
    logic [6:0]  byte_count;
    logic        end_of_call;
    logic [7:0]  entropy_byte;
    logic [31:0] timestamp_low;
  } in_item_t;

  typedef struct packed {
    logic [63:0] data_word;
    logic [3:0]  valid_bytes;
    logic        last_word;
  } out_item_t;

  // Job handed from front to back: a generate request.
  typedef struct packed {
    logic [6:0] byte_count;  // saturated to 64
    logic       rekey;
  } job_t;

  typedef logic [15:0][31:0] block_t;

  function automatic logic [31:0] rotl(logic [31:0] v, int unsigned n);
    return (v << n) | (v >> (32 - n));
  endfunction

  // One quarter round on four words.
  function automatic logic [127:0] qround(logic [31:0] a, logic [31:0] b,
                                          logic [31:0] c, logic [31:0] d);
    logic [31:0] ra;
    logic [31:0] rb;
    logic [31:0] rc;
    logic [31:0] rd;
    ra = a + b;  rd = rotl(d ^ ra, 16);
    rc = c + rd; rb = rotl(b ^ rc, 12);
    ra = ra + rb; rd = rotl(rd ^ ra, 8);
    rc = rc + rd; rb = rotl(rb ^ rc, 7);
    return {ra, rb, rc, rd};
  endfunction

  function automatic block_t double_round(block_t x);
    block_t y;
    block_t z;
    y = x;
    {y[0], y[4], y[8],  y[12]} = qround(x[0], x[4], x[8],  x[12]);
    {y[1], y[5], y[9],  y[13]} = qround(x[1], x[5], x[9],  x[13]);
    {y[2], y[6], y[10], y[14]} = qround(x[2], x[6], x[10], x[14]);
    {y[3], y[7], y[11], y[15]} = qround(x[3], x[7], x[11], x[15]);
    z = y;
    {z[0], z[5], z[10], z[15]} = qround(y[0], y[5], y[10], y[15]);
    {z[1], z[6], z[11], z[12]} = qround(y[1], y[6], y[11], y[12]);
    {z[2], z[7], z[8],  z[13]} = qround(y[2], y[7], y[8],  y[13]);
    {z[3], z[4], z[9],  z[14]} = qround(y[3], y[4], y[9],  y[14]);
    return z;
  endfunction

endpackage

FILE: hw/rtl/ccdrbg_front.sv
// ----------------------------------------------------------------------------
// ccdrbg_front
// Accepts items, decodes the mode and queues generate requests.
// Seed and entropy items need the key state, so the front waits until the
// back has drained all queued work before handling them.
// ----------------------------------------------------------------------------
module ccdrbg_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  ccdrbg_pkg::in_item_t  in_data,
  input  logic                  back_idle_i,
  output logic                  seed_o,
  output logic                  entropy_o,
  output ccdrbg_pkg::in_item_t  item_o,
  output logic                  job_valid_o,
  output ccdrbg_pkg::job_t      job_o,
  input  logic                  job_pop_i
);

  localparam int unsigned PtrW = $clog2(ccdrbg_pkg::QueueDepth);

  ccdrbg_pkg::job_t          fifo_q [ccdrbg_pkg::QueueDepth];
  logic [PtrW-1:0]           wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [PtrW:0]             cnt_q, cnt_d;
  logic                      is_gen, is_state, fifo_full, accept, push;
  ccdrbg_pkg::job_t          new_job;

  assign is_gen    = in_data.mode == ccdrbg_pkg::ModeGenerate;
  assign is_state  = in_data.mode == ccdrbg_pkg::ModeSeed ||
                     in_data.mode == ccdrbg_pkg::ModeEntropy;
  assign fifo_full = cnt_q == (PtrW+1)'(ccdrbg_pkg::QueueDepth);
  // Hold state-changing items until queued generates have run.
  assign in_stall  = is_gen ? fifo_full
                            : (is_state && !(back_idle_i && cnt_q == '0));
  assign accept    = in_valid && !in_stall;
  // Queue every generate: even an empty one seeds an unseeded core.
  assign push      = accept && is_gen;

  assign new_job.byte_count = (in_data.byte_count > 7'd64) ? 7'd64 : in_data.byte_count;
  assign new_job.rekey      = in_data.end_of_call;

  assign seed_o    = accept && in_data.mode == ccdrbg_pkg::ModeSeed;
  assign entropy_o = accept && in_data.mode == ccdrbg_pkg::ModeEntropy;
  assign item_o    = in_data;

  assign job_valid_o = cnt_q != '0;
  assign job_o       = fifo_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = job_pop_i ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q + (PtrW+1)'(push) - (PtrW+1)'(job_pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= new_job;
    end
  end

endmodule

FILE: hw/rtl/ccdrbg_back.sv
// ----------------------------------------------------------------------------
// ccdrbg_back
// Holds the ChaCha state, runs one double round per cycle and streams words.
// ----------------------------------------------------------------------------
module ccdrbg_back #(
  parameter int unsigned DoubleRounds = ccdrbg_pkg::DoubleRoundsDefault
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [ccdrbg_pkg::NumCfg-1:0][63:0] cfg_i,
  input  logic                  seed_i,
  input  logic                  entropy_i,
  input  ccdrbg_pkg::in_item_t  item_i,
  input  logic                  job_valid_i,
  input  ccdrbg_pkg::job_t      job_i,
  output logic                  job_pop_o,
  output logic                  idle_o,
  output logic                  out_valid,
  input  logic                  out_stall,
  output ccdrbg_pkg::out_item_t out_data
);

  localparam int unsigned RndW = $clog2(DoubleRounds + 1);

  typedef enum logic [3:0] {
    StIdle  = 4'b0001,
    StRound = 4'b0010,
    StEmit  = 4'b0100,
    StRekey = 4'b1000
  } state_e;

  state_e             st_q, st_d;
  logic [7:0][31:0]   key_q, key_d;
  logic [31:0]        ctr_q, ctr_d;
  logic [2:0][31:0]   nonce_q, nonce_d;
  logic               seeded_q, seeded_d;
  logic [3:0]         epos_q, epos_d;
  ccdrbg_pkg::block_t init_q, init_d, work_q, work_d;
  logic [RndW-1:0]    rnd_q, rnd_d;
  logic               is_key_q, is_key_d;
  logic [6:0]         left_q, left_d;
  logic [2:0]         widx_q, widx_d;
  logic               rekey_q, rekey_d;
  logic               ovalid_q, ovalid_d;
  ccdrbg_pkg::out_item_t odata_q, odata_d;
  ccdrbg_pkg::block_t fin;

  assign idle_o    = st_q == StIdle && !ovalid_q;
  assign out_valid = ovalid_q;
  assign out_data  = odata_q;

  always_comb begin
    for (int i = 0; i < 16; i++) fin[i] = work_q[i] + init_q[i];
  end

  function automatic ccdrbg_pkg::block_t mk(logic [7:0][31:0] k, logic [31:0] c,
                                            logic [2:0][31:0] n);
    ccdrbg_pkg::block_t b;
    b[0] = ccdrbg_pkg::Sigma0; b[1] = ccdrbg_pkg::Sigma1;
    b[2] = ccdrbg_pkg::Sigma2; b[3] = ccdrbg_pkg::Sigma3;
    for (int i = 0; i < 8; i++) b[4+i] = k[i];
    b[12] = c;
    for (int i = 0; i < 3; i++) b[13+i] = n[i];
    return b;
  endfunction

  always_comb begin
    logic [6:0]  vb;
    logic [63:0] w;
    logic [31:0] c1;
    logic [2:0][31:0] n1;
    logic [1:0]  lane;
    logic [1:0]  wsel;
    st_d = st_q; key_d = key_q; ctr_d = ctr_q; nonce_d = nonce_q;
    seeded_d = seeded_q; epos_d = epos_q; init_d = init_q; work_d = work_q;
    rnd_d = rnd_q; is_key_d = is_key_q; left_d = left_q; widx_d = widx_q;
    rekey_d = rekey_q; ovalid_d = ovalid_q; odata_d = odata_q;
    job_pop_o = 1'b0;
    vb = '0; w = '0; c1 = '0; n1 = nonce_q; lane = '0; wsel = '0;

    if (ovalid_q && !out_stall) ovalid_d = 1'b0;

    if (seed_i) begin
      for (int i = 0; i < 4; i++) begin
        key_d[2*i]   = cfg_i[i][31:0];
        key_d[2*i+1] = cfg_i[i][63:32];
      end
      for (int i = 0; i < 3; i++) nonce_d[i] = cfg_i[4+i][31:0];
      ctr_d = '0; seeded_d = 1'b1; epos_d = '0;
    end
    if (entropy_i) begin
      lane = epos_q[1:0];
      wsel = (epos_q >= 4'd9) ? 2'(epos_q - 4'd9) :
             (epos_q >= 4'd6) ? 2'(epos_q - 4'd6) :
             (epos_q >= 4'd3) ? 2'(epos_q - 4'd3) : epos_q[1:0];
      nonce_d[wsel] = nonce_q[wsel] ^ ({24'd0, item_i.entropy_byte} << {lane, 3'd0});
      if (item_i.end_of_call) begin
        nonce_d[1] = nonce_d[1] ^ item_i.timestamp_low;
        epos_d = '0;
      end else begin
        epos_d = (epos_q == 4'd11) ? 4'd0 : epos_q + 4'd1;
      end
    end

    case (st_q)
      StIdle: begin
        if (job_valid_i) begin
          job_pop_o = 1'b1;
          if (!seeded_q) begin
            for (int i = 0; i < 4; i++) begin
              key_d[2*i]   = cfg_i[i][31:0];
              key_d[2*i+1] = cfg_i[i][63:32];
            end
            for (int i = 0; i < 3; i++) n1[i] = cfg_i[4+i][31:0];
            c1 = '0; seeded_d = 1'b1; epos_d = '0;
          end else begin
            c1 = ctr_q;
          end
          if (job_i.byte_count == '0 && !job_i.rekey) begin
            // Nothing to emit and no rekey: only the implicit seed lands.
            ctr_d = c1; nonce_d = n1;
          end else begin
            rekey_d = job_i.rekey;
            left_d  = job_i.byte_count;
            widx_d  = '0;
            rnd_d   = '0;
            c1 = c1 + 32'd1;
            if (job_i.byte_count != '0) begin
              if (c1 == '0) n1[0] = n1[0] + 32'd1;
              is_key_d = 1'b0;
            end else begin
              is_key_d = 1'b1;
            end
            ctr_d = c1; nonce_d = n1;
            init_d = mk(key_d, c1, n1);
            work_d = init_d;
            st_d = StRound;
          end
        end
      end
      StRound: begin
        work_d = ccdrbg_pkg::double_round(work_q);
        rnd_d  = rnd_q + 1'b1;
        if (rnd_q == RndW'(DoubleRounds - 1)) st_d = is_key_q ? StRekey : StEmit;
      end
      StEmit: begin
        if (!ovalid_q || !out_stall) begin
          vb = (left_q > 7'd8) ? 7'd8 : left_q;
          w  = {fin[{widx_q, 1'b1}], fin[{widx_q, 1'b0}]};
          for (int b = 0; b < 8; b++) if (7'(b) >= vb) w[b*8 +: 8] = 8'd0;
          odata_d.data_word   = w;
          odata_d.valid_bytes = vb[3:0];
          odata_d.last_word   = left_q <= 7'd8;
          ovalid_d = 1'b1;
          left_d = left_q - vb;
          widx_d = widx_q + 3'd1;
          if (left_q <= 7'd8) begin
            if (rekey_q) begin
              ctr_d = ctr_q + 32'd1;
              init_d = mk(key_q, ctr_q + 32'd1, nonce_q);
              work_d = init_d;
              rnd_d = '0; is_key_d = 1'b1;
              st_d = StRound;
            end else begin
              st_d = StIdle;
            end
          end
        end
      end
      StRekey: begin
        for (int i = 0; i < 8; i++) key_d[i] = fin[i];
        nonce_d[1] = nonce_q[1] ^ fin[8];
        nonce_d[2] = nonce_q[2] ^ fin[9];
        st_d = StIdle;
      end
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle; key_q <= '0; ctr_q <= '0; nonce_q <= '0;
      seeded_q <= 1'b0; epos_q <= '0; ovalid_q <= 1'b0;
    end else begin
      st_q <= st_d; key_q <= key_d; ctr_q <= ctr_d; nonce_q <= nonce_d;
      seeded_q <= seeded_d; epos_q <= epos_d; ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    init_q <= init_d; work_q <= work_d; rnd_q <= rnd_d; is_key_q <= is_key_d;
    left_q <= left_d; widx_q <= widx_d; rekey_q <= rekey_d; odata_q <= odata_d;
  end

endmodule

FILE: hw/rtl/chacha20_keystream_drbg.sv
// ----------------------------------------------------------------------------
// chacha20_keystream_drbg
// ChaCha20 keystream generator with forward-secure rekeying.
// ----------------------------------------------------------------------------
// A generate item leaves the queue, runs DoubleRounds double rounds (10 by
// default) in the shared double-round unit and then emits up to eight beats,
// holding while the output stalls; a rekey adds a further pass through the
// double-round unit and a key update. A generate with nothing to emit and
// no rekey does not enter the double-round unit. Up to two generate items
// queue ahead of the core;
// seed and entropy items wait for the queue and core to drain, then take
// effect in the accepting cycle. Configuration registers are plain
// write-only; seeding copies them into the key state.
module chacha20_keystream_drbg #(
  parameter int unsigned DoubleRounds = ccdrbg_pkg::DoubleRoundsDefault
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  ccdrbg_pkg::in_item_t              in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output ccdrbg_pkg::out_item_t             out_data,
  input  logic                              cfg_we_i,
  input  logic [ccdrbg_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [ccdrbg_pkg::CfgDataW-1:0]   cfg_data_i
);

  logic [ccdrbg_pkg::NumCfg-1:0][63:0] cfg_q;
  logic                 seed, entropy, job_valid, job_pop, back_idle;
  ccdrbg_pkg::in_item_t item;
  ccdrbg_pkg::job_t     job;

  // Nonce registers keep only their low 32 bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ccdrbg_pkg::CfgSeed0:  cfg_q[0] <= cfg_data_i;
        ccdrbg_pkg::CfgSeed1:  cfg_q[1] <= cfg_data_i;
        ccdrbg_pkg::CfgSeed2:  cfg_q[2] <= cfg_data_i;
        ccdrbg_pkg::CfgSeed3:  cfg_q[3] <= cfg_data_i;
        ccdrbg_pkg::CfgNonceA: cfg_q[4] <= {32'd0, cfg_data_i[31:0]};
        ccdrbg_pkg::CfgNonceB: cfg_q[5] <= {32'd0, cfg_data_i[31:0]};
        ccdrbg_pkg::CfgNonceC: cfg_q[6] <= {32'd0, cfg_data_i[31:0]};
        default: ;
      endcase
    end
  end

  ccdrbg_front u_front (
    .clk_i, .rst_ni, .in_valid, .in_stall, .in_data,
    .back_idle_i(back_idle), .seed_o(seed), .entropy_o(entropy), .item_o(item),
    .job_valid_o(job_valid), .job_o(job), .job_pop_i(job_pop)
  );

  ccdrbg_back #(.DoubleRounds(DoubleRounds)) u_back (
    .clk_i, .rst_ni, .cfg_i(cfg_q), .seed_i(seed), .entropy_i(entropy),
    .item_i(item), .job_valid_i(job_valid), .job_i(job), .job_pop_o(job_pop),
    .idle_o(back_idle), .out_valid, .out_stall, .out_data
  );

endmodule
